[rtl/core/dica_pkg.sv]
// Package for the delta increment channel accumulator.
// Holds the decoded operation type and fixed constants; no dependencies.
package dica_pkg;

    localparam int IN_INC_BITS   = 8;
    localparam int FULL_BITS     = 16;
    localparam int CHAN_BITS     = 2;
    localparam int QUANT_BITS    = 9;
    localparam int VALUE_BITS    = 18;
    localparam int STEP_BITS     = 13;
    localparam int CFG_IDX_BITS  = 2;
    localparam int NUM_CHAN      = 3;
    localparam int WRAP_SPAN     = 4000;
    localparam int QUANT_MAX     = 256;

    localparam logic [CFG_IDX_BITS-1:0] REG_MODE    = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_QUANT_1 = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_QUANT_2 = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_QUANT_3 = 2'd3;

    localparam logic [CHAN_BITS-1:0] CHAN_ONE   = 2'd0;
    localparam logic [CHAN_BITS-1:0] CHAN_TWO   = 2'd1;
    localparam logic [CHAN_BITS-1:0] CHAN_THREE = 2'd2;

    localparam logic CMD_INCREMENT = 1'b0;
    localparam logic CMD_RESYNC    = 1'b1;

    typedef struct packed {
        logic [NUM_CHAN-1:0]         mask;
        logic                        load;
        logic                        wrap;
        logic [FULL_BITS-1:0]        full;
        logic signed [STEP_BITS-1:0] step_one;
        logic signed [STEP_BITS-1:0] step_two;
        logic signed [STEP_BITS-1:0] step_three;
    } t_op;

endpackage

[rtl/core/delta_increment_channel_accumulator.sv]
// Top level of the delta increment channel accumulator: configuration
// registers, front end, operation queue and back end. Depends on dica_pkg.
//
// Each input transfer is decoded in the cycle it is taken and, when it changes
// at least one channel, placed in a two-entry queue; transfers that change no
// channel produce no result. While the output is not stalled, the back end
// updates one channel counter per cycle and emits one result per cycle, so an
// item with n changed channels (1 to 3) yields n results and the sustained rate
// is one result per cycle. The input stalls only when the queue holds two
// pending items.
module delta_increment_channel_accumulator
    import dica_pkg::*;
#(
    parameter int COUNTER_BITS = 18
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic                    i_cmd,
    input  logic [IN_INC_BITS-1:0]  i_increment,
    input  logic [CHAN_BITS-1:0]    i_channel,
    input  logic [FULL_BITS-1:0]    i_full_value,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [CHAN_BITS-1:0]    o_out_channel,
    output logic signed [VALUE_BITS-1:0] o_value,
    output logic                    o_last,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [QUANT_BITS-1:0]   i_cfg_data
);

    logic                  r_mode;
    logic [QUANT_BITS-1:0] r_quant_one;
    logic [QUANT_BITS-1:0] r_quant_two;
    logic [QUANT_BITS-1:0] r_quant_three;

    logic                  w_full;
    logic                  w_push;
    t_op                   w_op;
    logic                  w_pop;
    logic                  w_head_valid;
    t_op                   w_head;
    logic [VALUE_BITS-1:0] w_value;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= 1'b0;
            r_quant_one   <= QUANT_BITS'(1);
            r_quant_two   <= QUANT_BITS'(1);
            r_quant_three <= QUANT_BITS'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_MODE:    r_mode        <= i_cfg_data[0];
                REG_QUANT_1: r_quant_one   <= i_cfg_data;
                REG_QUANT_2: r_quant_two   <= i_cfg_data;
                REG_QUANT_3: r_quant_three <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_in_stall = w_full;

    dica_front u_front (
        .i_accept      (i_in_valid && !w_full),
        .i_cmd         (i_cmd),
        .i_increment   (i_increment),
        .i_channel     (i_channel),
        .i_full_value  (i_full_value),
        .i_mode        (r_mode),
        .i_quant_one   (r_quant_one),
        .i_quant_two   (r_quant_two),
        .i_quant_three (r_quant_three),
        .o_push        (w_push),
        .o_op          (w_op)
    );

    dica_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .i_op         (w_op),
        .i_pop        (w_pop),
        .o_full       (w_full),
        .o_head_valid (w_head_valid),
        .o_head       (w_head)
    );

    dica_back #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head_valid  (w_head_valid),
        .i_head        (w_head),
        .o_pop         (w_pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_channel (o_out_channel),
        .o_value       (w_value),
        .o_last        (o_last)
    );

    assign o_value = $signed(w_value);

endmodule

[rtl/core/dica_front.sv]
// Front end: decodes one input item into per-channel step or load operations.
// Depends on dica_pkg.
module dica_front
    import dica_pkg::*;
(
    input  logic                   i_accept,
    input  logic                   i_cmd,
    input  logic [IN_INC_BITS-1:0] i_increment,
    input  logic [CHAN_BITS-1:0]   i_channel,
    input  logic [FULL_BITS-1:0]   i_full_value,
    input  logic                   i_mode,
    input  logic [QUANT_BITS-1:0]  i_quant_one,
    input  logic [QUANT_BITS-1:0]  i_quant_two,
    input  logic [QUANT_BITS-1:0]  i_quant_three,
    output logic                   o_push,
    output t_op                    o_op
);

    function automatic logic [QUANT_BITS-1:0] eff_quant(input logic [QUANT_BITS-1:0] q);
        logic [QUANT_BITS-1:0] r;
        r = q;
        if (q == '0) r = QUANT_BITS'(1);
        else if (q > QUANT_BITS'(QUANT_MAX)) r = QUANT_BITS'(QUANT_MAX);
        return r;
    endfunction

    function automatic logic signed [STEP_BITS-1:0] make_step(
        input logic [2:0]            mag,
        input logic [QUANT_BITS-1:0] q,
        input logic                  down
    );
        logic [STEP_BITS-2:0]        amt;
        logic signed [STEP_BITS-1:0] s;
        amt = (STEP_BITS-1)'(mag * q);
        s   = $signed({1'b0, amt});
        return down ? -s : s;
    endfunction

    logic [QUANT_BITS-1:0] w_q1;
    logic [QUANT_BITS-1:0] w_q2;
    logic [QUANT_BITS-1:0] w_q3;
    t_op                   w_op;

    assign w_q1 = eff_quant(i_quant_one);
    assign w_q2 = eff_quant(i_quant_two);
    assign w_q3 = eff_quant(i_quant_three);

    always_comb begin
        w_op            = '0;
        w_op.full       = i_full_value;
        w_op.step_one   = make_step(i_increment[2:0], w_q1, i_increment[3]);
        if (i_cmd == CMD_RESYNC) begin
            w_op.load = 1'b1;
            case (i_channel)
                CHAN_ONE:   w_op.mask = 3'b001;
                CHAN_TWO:   w_op.mask = 3'b010;
                CHAN_THREE: w_op.mask = i_mode ? 3'b100 : 3'b000;
                default:    w_op.mask = 3'b000;
            endcase
        end else begin
            w_op.mask[0] = i_increment[2:0] != 3'd0;
            if (!i_mode) begin
                w_op.mask[1]  = i_increment[6:4] != 3'd0;
                w_op.step_two = make_step(i_increment[6:4], w_q2, i_increment[7]);
            end else begin
                w_op.wrap       = 1'b1;
                w_op.mask[1]    = i_increment[4];
                w_op.mask[2]    = i_increment[6];
                w_op.step_two   = make_step(3'd1, w_q2, i_increment[5]);
                w_op.step_three = make_step(3'd1, w_q3, i_increment[7]);
            end
        end
    end

    assign o_op   = w_op;
    assign o_push = i_accept && (w_op.mask != '0);

endmodule

[rtl/core/dica_queue.sv]
// Two-entry queue of decoded operations between front and back end.
// Depends on dica_pkg.
module dica_queue
    import dica_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_op  i_op,
    input  logic i_pop,
    output logic o_full,
    output logic o_head_valid,
    output t_op  o_head
);

    t_op        r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) n_cnt = r_cnt + 2'd1;
        else if (!i_push && i_pop) n_cnt = r_cnt - 2'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_op;
    end

    assign o_full       = r_cnt == 2'd2;
    assign o_head_valid = r_cnt != 2'd0;
    assign o_head       = r_mem[r_rp];

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count out of range");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_cnt != 2'd0) else $error("pop from empty queue");

endmodule

[rtl/core/dica_back.sv]
// Back end: applies one channel operation per cycle to the counters while the
// output is not stalled, and drives the result register. Depends on dica_pkg.
module dica_back
    import dica_pkg::*;
#(
    parameter int COUNTER_BITS = 18
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_head_valid,
    input  t_op                   i_head,
    output logic                  o_pop,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [CHAN_BITS-1:0]  o_out_channel,
    output logic [VALUE_BITS-1:0] o_value,
    output logic                  o_last
);

    localparam int W  = COUNTER_BITS + 2;
    localparam int EW = (COUNTER_BITS > VALUE_BITS) ? COUNTER_BITS : VALUE_BITS;
    localparam logic signed [W-1:0] SAT_HI = W'((64'sd1 <<< (COUNTER_BITS - 1)) - 64'sd1);
    localparam logic signed [W-1:0] SAT_LO = -SAT_HI - W'(1);
    localparam logic signed [W-1:0] SPAN   = W'(WRAP_SPAN);

    logic signed [COUNTER_BITS-1:0] r_ctr [NUM_CHAN];
    logic [NUM_CHAN-1:0]            r_done;
    logic                           r_out_valid;
    logic [CHAN_BITS-1:0]           r_out_channel;
    logic [VALUE_BITS-1:0]          r_value;
    logic                           r_last;

    logic [NUM_CHAN-1:0]            w_pend;
    logic [NUM_CHAN-1:0]            w_sel_hot;
    logic [CHAN_BITS-1:0]           w_sel;
    logic                           w_fire;
    logic                           w_last;
    logic signed [STEP_BITS-1:0]    w_step;
    logic signed [W-1:0]            w_sum;
    logic signed [W-1:0]            w_wrapped;
    logic signed [W-1:0]            w_sat;
    logic signed [COUNTER_BITS-1:0] n_ctr;
    logic signed [EW-1:0]           w_ext;

    assign w_pend = i_head.mask & ~r_done;

    always_comb begin
        if (w_pend[0]) begin
            w_sel = CHAN_ONE;   w_sel_hot = 3'b001; w_step = i_head.step_one;
        end else if (w_pend[1]) begin
            w_sel = CHAN_TWO;   w_sel_hot = 3'b010; w_step = i_head.step_two;
        end else begin
            w_sel = CHAN_THREE; w_sel_hot = 3'b100; w_step = i_head.step_three;
        end
    end

    assign w_fire = i_head_valid && (!r_out_valid || !i_out_stall);
    assign w_last = (w_pend & ~w_sel_hot) == '0;
    assign o_pop  = w_fire && w_last;

    always_comb begin
        if (i_head.load) begin
            w_sum = W'($signed({1'b0, i_head.full}));
        end else begin
            w_sum = W'(r_ctr[w_sel[1:0]]) + W'(w_step);
        end
        w_wrapped = w_sum;
        if (!i_head.load && i_head.wrap && w_sel != CHAN_ONE) begin
            if (w_sum >= SPAN) w_wrapped = w_sum - SPAN;
            else if (w_sum < 0) w_wrapped = w_sum + SPAN;
        end
        if (w_wrapped > SAT_HI) w_sat = SAT_HI;
        else if (w_wrapped < SAT_LO) w_sat = SAT_LO;
        else w_sat = w_wrapped;
        n_ctr = w_sat[COUNTER_BITS-1:0];
        w_ext = EW'(n_ctr);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctr[0]    <= '0;
            r_ctr[1]    <= '0;
            r_ctr[2]    <= '0;
            r_done      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_fire) begin
                r_ctr[w_sel[1:0]] <= n_ctr;
                r_done            <= w_last ? '0 : (r_done | w_sel_hot);
                r_out_valid       <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_channel <= w_sel;
            r_value       <= w_ext[VALUE_BITS-1:0];
            r_last        <= w_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_channel = r_out_channel;
    assign o_value       = r_value;
    assign o_last        = r_last;

    a_head_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_head_valid |-> w_pend != '0) else $error("queue head has no pending channel");
    a_done_subset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_head_valid |-> (r_done & ~i_head.mask) == '0) else $error("done bits outside mask");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_head_valid |-> r_done == '0) else $error("done bits left without head");
    a_chan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_channel != 2'd3) else $error("bad result channel");

endmodule

[test/tb_top.sv]
`timescale 1ns / 100ps
// Testbench for delta_increment_channel_accumulator: directed and random increment
// and resync transfers under several register settings, with random idle on both
// sides. Depends on dica_pkg and the accumulator RTL.
module tb_top;
    import dica_pkg::*;

    localparam int COUNTER_BITS   = 18;
    localparam int WATCHDOG_LIMIT = 2000;

    localparam logic                 MODE_PAIR   = 1'b0;
    localparam logic                 MODE_TRIPLE = 1'b1;
    localparam logic [CHAN_BITS-1:0] CHAN_SPARE  = 2'd3;

    typedef struct {
        logic [CHAN_BITS-1:0]         chan;
        logic signed [VALUE_BITS-1:0] value;
        logic                         last;
    } t_chan_result;

    class t_channel_tracker;
        logic                           mode;
        logic [QUANT_BITS-1:0]          quant [NUM_CHAN];
        logic signed [COUNTER_BITS-1:0] counter [NUM_CHAN];
        t_chan_result                   pending [$];
        int                             errors;

        function new();
            mode   = MODE_PAIR;
            errors = 0;
            for (int k = 0; k < NUM_CHAN; k++) begin
                quant[k]   = QUANT_BITS'(1);
                counter[k] = '0;
            end
        endfunction

        function void set_register(logic [CFG_IDX_BITS-1:0] idx, logic [QUANT_BITS-1:0] data);
            case (idx)
                REG_MODE:    mode     = data[0];
                REG_QUANT_1: quant[0] = data;
                REG_QUANT_2: quant[1] = data;
                REG_QUANT_3: quant[2] = data;
                default: ;
            endcase
        endfunction

        static function int step_size(logic [QUANT_BITS-1:0] q);
            if (q == 0) return 1;
            if (q > QUANT_MAX) return QUANT_MAX;
            return int'(q);
        endfunction

        static function int clamp(int v);
            int hi;
            hi = (1 << (COUNTER_BITS - 1)) - 1;
            if (v > hi) return hi;
            if (v < -hi - 1) return -hi - 1;
            return v;
        endfunction

        static function int wrap_span(int v);
            if (v >= WRAP_SPAN) return v - WRAP_SPAN;
            if (v < 0) return v + WRAP_SPAN;
            return v;
        endfunction

        function void note_item(logic cmd, logic [IN_INC_BITS-1:0] inc,
                                logic [CHAN_BITS-1:0] chan, logic [FULL_BITS-1:0] full);
            logic [NUM_CHAN-1:0] hit;
            int                  amt;
            t_chan_result        r;
            hit = '0;
            if (cmd == CMD_RESYNC) begin
                if (chan == CHAN_ONE || chan == CHAN_TWO ||
                    (chan == CHAN_THREE && mode == MODE_TRIPLE)) begin
                    counter[chan] = COUNTER_BITS'(clamp(int'(full)));
                    hit[chan]     = 1'b1;
                end
            end else begin
                if (inc[2:0] != 0) begin
                    amt        = int'(inc[2:0]) * step_size(quant[0]);
                    counter[0] = COUNTER_BITS'(clamp(counter[0] + (inc[3] ? -amt : amt)));
                    hit[0]     = 1'b1;
                end
                if (mode == MODE_PAIR) begin
                    if (inc[6:4] != 0) begin
                        amt        = int'(inc[6:4]) * step_size(quant[1]);
                        counter[1] = COUNTER_BITS'(clamp(counter[1] + (inc[7] ? -amt : amt)));
                        hit[1]     = 1'b1;
                    end
                end else begin
                    if (inc[4]) begin
                        amt        = step_size(quant[1]);
                        counter[1] = COUNTER_BITS'(
                            clamp(wrap_span(counter[1] + (inc[5] ? -amt : amt))));
                        hit[1]     = 1'b1;
                    end
                    if (inc[6]) begin
                        amt        = step_size(quant[2]);
                        counter[2] = COUNTER_BITS'(
                            clamp(wrap_span(counter[2] + (inc[7] ? -amt : amt))));
                        hit[2]     = 1'b1;
                    end
                end
            end
            for (int k = 0; k < NUM_CHAN; k++) begin
                if (hit[k]) begin
                    r.chan  = CHAN_BITS'(k);
                    r.value = counter[k];
                    r.last  = (hit >> (k + 1)) == 0;
                    pending.push_back(r);
                end
            end
        endfunction

        function void check_result(logic [CHAN_BITS-1:0] chan,
                                   logic signed [VALUE_BITS-1:0] value, logic last);
            t_chan_result want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result, channel %0d value %0d last %0b",
                         $time, chan, value, last);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (chan !== want.chan) begin
                $display("%0t: channel expected %0d actual %0d", $time, want.chan, chan);
                errors++;
            end
            if (value !== want.value) begin
                $display("%0t: value (channel %0d) expected %0d actual %0d",
                         $time, want.chan, want.value, value);
                errors++;
            end
            if (last !== want.last) begin
                $display("%0t: last expected %0b actual %0b", $time, want.last, last);
                errors++;
            end
        endfunction
    endclass

    logic                         i_clk        = 1'b0;
    logic                         i_rst_n      = 1'b0;
    logic                         i_in_valid   = 1'b0;
    logic                         o_in_stall;
    logic                         i_cmd        = CMD_INCREMENT;
    logic [IN_INC_BITS-1:0]       i_increment  = '0;
    logic [CHAN_BITS-1:0]         i_channel    = '0;
    logic [FULL_BITS-1:0]         i_full_value = '0;
    logic                         o_out_valid;
    logic                         i_out_stall  = 1'b0;
    logic [CHAN_BITS-1:0]         o_out_channel;
    logic signed [VALUE_BITS-1:0] o_value;
    logic                         o_last;
    logic                         i_cfg_valid  = 1'b0;
    logic                         o_cfg_ready;
    logic [CFG_IDX_BITS-1:0]      i_cfg_index  = '0;
    logic [QUANT_BITS-1:0]        i_cfg_data   = '0;

    t_channel_tracker tracker;
    bit               jitter_on    = 1'b1;
    int               stall_hold   = 0;
    int               quiet_cycles = 0;

    delta_increment_channel_accumulator #(
        .COUNTER_BITS(COUNTER_BITS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_cmd        (i_cmd),
        .i_increment  (i_increment),
        .i_channel    (i_channel),
        .i_full_value (i_full_value),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_channel(o_out_channel),
        .o_value      (o_value),
        .o_last       (o_last),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        if (stall_hold != 0) begin
            stall_hold <= stall_hold - 1;
        end else if (jitter_on && $urandom_range(0, 5) == 0) begin
            i_out_stall <= 1'b1;
            stall_hold  <= $urandom_range(0, 7);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            tracker.check_result(o_out_channel, o_value, o_last);
    end

    // cycles with no transfer on any channel
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_item(input logic cmd, input logic [IN_INC_BITS-1:0] inc,
                             input logic [CHAN_BITS-1:0] chan,
                             input logic [FULL_BITS-1:0] full);
        int gap;
        @(negedge i_clk);
        if (jitter_on && $urandom_range(0, 4) == 0) begin
            gap        = $urandom_range(1, 8);
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid   = 1'b1;
        i_cmd        = cmd;
        i_increment  = inc;
        i_channel    = chan;
        i_full_value = full;
        do @(posedge i_clk); while (o_in_stall);
        tracker.note_item(cmd, inc, chan, full);
    endtask

    task automatic wait_for_results(input int extra);
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (tracker.pending.size() != 0) @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [QUANT_BITS-1:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        tracker.set_register(idx, data);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic apply_setting(input logic mode, input logic [QUANT_BITS-1:0] q1,
                                 input logic [QUANT_BITS-1:0] q2,
                                 input logic [QUANT_BITS-1:0] q3);
        wait_for_results(8);
        write_reg(REG_MODE, QUANT_BITS'(mode));
        write_reg(REG_QUANT_1, q1);
        write_reg(REG_QUANT_2, q2);
        write_reg(REG_QUANT_3, q3);
    endtask

    task automatic random_item();
        logic [FULL_BITS-1:0] full;
        int                   pick;
        pick = $urandom_range(0, 99);
        full = $urandom_range(0, 65535);
        if (pick < 8)
            full = '1;
        else if (pick < 12)
            full = '0;
        if ($urandom_range(0, 99) < 78)
            send_item(CMD_INCREMENT, 8'($urandom), 2'($urandom), full);
        else
            send_item(CMD_RESYNC, 8'($urandom), 2'($urandom), full);
    endtask

    // pair mode, large quanta: long one-way runs; the upward run can push both counters into saturation
    task automatic drift_run(input logic down, input int steps);
        send_item(CMD_RESYNC, 8'($urandom), CHAN_ONE, down ? '0 : 16'($urandom));
        send_item(CMD_RESYNC, 8'($urandom), CHAN_TWO, down ? '0 : 16'($urandom));
        repeat (steps)
            send_item(CMD_INCREMENT, {down, 3'($urandom_range(6, 7)),
                                      down, 3'($urandom_range(6, 7))},
                      2'($urandom), 16'($urandom));
    endtask

    initial begin
        tracker = new();
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // pair mode, reset quanta
        send_item(CMD_INCREMENT, 8'h00, CHAN_ONE, 16'h0000);
        send_item(CMD_INCREMENT, 8'h77, CHAN_ONE, 16'h0000);
        send_item(CMD_INCREMENT, 8'hFF, CHAN_ONE, 16'h0000);
        send_item(CMD_INCREMENT, 8'h88, CHAN_ONE, 16'h0000);
        send_item(CMD_INCREMENT, 8'h09, CHAN_ONE, 16'h0000);
        send_item(CMD_INCREMENT, 8'h10, CHAN_ONE, 16'h0000);
        send_item(CMD_RESYNC,    8'h00, CHAN_ONE, 16'hFFFF);
        send_item(CMD_RESYNC,    8'h00, CHAN_TWO, 16'h0000);
        send_item(CMD_RESYNC,    8'h00, CHAN_THREE, 16'h1234);
        send_item(CMD_RESYNC,    8'h00, CHAN_SPARE, 16'hFFFF);
        send_item(CMD_INCREMENT, 8'h0F, CHAN_ONE, 16'h0000);

        // triple mode, quanta below and above the legal range
        apply_setting(MODE_TRIPLE, 9'd0, 9'd511, 9'd256);
        send_item(CMD_INCREMENT, 8'h10, CHAN_ONE, 16'h0000);
        send_item(CMD_INCREMENT, 8'h30, CHAN_ONE, 16'h0000);
        send_item(CMD_INCREMENT, 8'h30, CHAN_ONE, 16'h0000);
        send_item(CMD_RESYNC,    8'h00, CHAN_THREE, 16'd3999);
        send_item(CMD_INCREMENT, 8'h40, CHAN_ONE, 16'h0000);
        send_item(CMD_INCREMENT, 8'hC0, CHAN_ONE, 16'h0000);
        send_item(CMD_RESYNC,    8'h00, CHAN_TWO, 16'hFFFF);
        send_item(CMD_INCREMENT, 8'h10, CHAN_ONE, 16'h0000);
        send_item(CMD_INCREMENT, 8'hFF, CHAN_ONE, 16'h0000);
        send_item(CMD_INCREMENT, 8'h57, CHAN_ONE, 16'h0000);
        send_item(CMD_RESYNC,    8'h00, CHAN_SPARE, 16'h0001);
        send_item(CMD_INCREMENT, 8'hA8, CHAN_ONE, 16'h0000);

        apply_setting(MODE_PAIR, 9'd256, 9'd300, 9'd1);
        drift_run(1'b1, 72);
        drift_run(1'b0, 72);
        repeat (20) random_item();

        apply_setting(MODE_TRIPLE, 9'd1, 9'd1, 9'd1);
        repeat (25) random_item();
        wait_for_results(0);
        repeat (25) random_item();

        apply_setting(MODE_TRIPLE, 9'd200, 9'd3, 9'd256);
        repeat (50) random_item();

        apply_setting(MODE_PAIR, 9'd3, 9'd511, 9'd0);
        repeat (50) random_item();

        apply_setting(MODE_TRIPLE, 9'($urandom), 9'($urandom), 9'($urandom));
        repeat (50) random_item();

        apply_setting(1'($urandom), 9'($urandom), 9'($urandom), 9'($urandom));
        jitter_on = 1'b0;
        repeat (40) random_item();

        wait_for_results(16);
        if (tracker.errors == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end
endmodule

[filelist.f]
rtl/core/dica_pkg.sv
rtl/core/dica_front.sv
rtl/core/dica_queue.sv
rtl/core/dica_back.sv
rtl/core/delta_increment_channel_accumulator.sv
test/tb_top.sv
